### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the marker position ring queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define MPRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a rising clock edge outside reset.
`define MPRQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MPRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MPRQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hdl/mprq_pkg.sv
// Package with the constants, types and slot helpers of the marker position ring queue.
package mprq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int POS_W = 16;
    localparam int CNT_W = 4;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 56;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [POS_W-1:0] pos_t;

    // Action codes carried on the input tuser.
    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_REBASE = 2'd3
    } action_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PUT   = 7'b0000010,
        ST_POP   = 7'b0000100,
        ST_RB    = 7'b0001000,
        ST_FIRST = 7'b0010000,
        ST_LAST  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Result of the shared compare and rebase unit.
    typedef struct packed {
        logic ge;
        logic eq;
        pos_t rebased;
    } alu_res_t;

    function automatic idx_t next_slot(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t prev_slot(input idx_t i);
        return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

endpackage

### hdl/marker_position_ring_queue_top.sv
// Top level of the marker position ring queue: sequencer, indexes and output register.
//
// The block keeps a ring queue of up to DEPTH-1 marker positions.
// Input channel s_*: one item per action; tuser carries the action code and
// tdata the position, buffer start and buffer end. Output channel m_*: exactly
// one item per input item, with the queue status after the action.
// The marker store has a single registered read port, and the sequencer reads
// through it one entry per cycle. A put runs the PUT step, a pop on a non-empty
// queue POP, a rebase on a non-empty queue RB once per stored entry, and clear
// and a pop or rebase on an empty queue none; all then run FIRST, LAST, DONE.
// The next item can be accepted in the cycle after the result is loaded into
// the output register. Reset empties the queue at once, with no clearing pass;
// the store contents are not cleared, since unwritten entries are never used.
// When the receiver stalls, the result stays in the output register; the next
// item may still be accepted and worked on, and its result waits in the last
// sequencer step until the output register is free.
`include "assert_macros.svh"

module marker_position_ring_queue_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [15:0] position, [31:16] buffer_start, [47:32] buffer_end
    input  logic [mprq_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] action
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] not_empty, [16:1] first_position, [32:17] last_position,
    // [33] popped_valid, [49:34] popped_position, [50] overflow,
    // [54:51] entry_count, [55] zero
    output logic [mprq_pkg::OUT_DATA_W-1:0]    m_tdata
);

    mprq_pkg::state_t  state_reg, state_next;
    mprq_pkg::idx_t    rd_idx_reg, rd_idx_next;
    mprq_pkg::idx_t    wr_idx_reg, wr_idx_next;
    mprq_pkg::idx_t    walk_reg, walk_next;
    mprq_pkg::action_t act_reg, act_next;
    mprq_pkg::pos_t    pos_reg, pos_next;
    mprq_pkg::pos_t    bstart_reg, bstart_next;
    mprq_pkg::pos_t    bend_reg, bend_next;
    mprq_pkg::pos_t    first_reg, first_next;
    mprq_pkg::pos_t    popped_reg, popped_next;
    logic              pv_reg, pv_next;
    logic              ovf_reg, ovf_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [mprq_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    mprq_pkg::idx_t     raddr;
    mprq_pkg::idx_t     waddr;
    mprq_pkg::pos_t     wdata;
    mprq_pkg::pos_t     rdata;
    logic               we;
    mprq_pkg::alu_res_t alu;
    logic               accept;
    logic               nonempty;
    logic               out_free;
    logic               out_load;
    logic [mprq_pkg::IDX_W:0] count;
    mprq_pkg::action_t  in_action;

    assign in_action = mprq_pkg::action_t'(s_tuser);
    assign s_tready  = (state_reg == mprq_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign nonempty  = (rd_idx_reg != wr_idx_reg);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == mprq_pkg::ST_DONE) && out_free;

    // Number of stored entries, wrapping around the ring.
    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            count = {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};
        end
        else
        begin
            count = (mprq_pkg::IDX_W+1)'({1'b0, wr_idx_reg}
                    + (mprq_pkg::IDX_W+1)'(mprq_pkg::DEPTH)) - {1'b0, rd_idx_reg};
        end
    end

    mprq_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    mprq_alu u_alu (
        .value        (rdata),
        .position     (pos_reg),
        .buffer_start (bstart_reg),
        .buffer_end   (bend_reg),
        .res          (alu)
    );

    // Sequencer: issues one store read per cycle and applies the shared unit.
    always_comb
    begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        walk_next     = walk_reg;
        act_next      = act_reg;
        pos_next      = pos_reg;
        bstart_next   = bstart_reg;
        bend_next     = bend_reg;
        first_next    = first_reg;
        popped_next   = popped_reg;
        pv_next       = pv_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        raddr         = rd_idx_reg;
        waddr         = wr_idx_reg;
        wdata         = pos_reg;
        we            = 1'b0;

        unique case (state_reg)
            mprq_pkg::ST_IDLE:
            begin
                if (in_action == mprq_pkg::ACT_PUT)
                begin
                    raddr = mprq_pkg::prev_slot(wr_idx_reg);
                end
                if (accept)
                begin
                    act_next    = in_action;
                    pos_next    = s_tdata[15:0];
                    bstart_next = s_tdata[31:16];
                    bend_next   = s_tdata[47:32];
                    walk_next   = rd_idx_reg;
                    pv_next     = 1'b0;
                    popped_next = '0;
                    ovf_next    = 1'b0;
                    unique case (in_action)
                        mprq_pkg::ACT_PUT:
                        begin
                            state_next = mprq_pkg::ST_PUT;
                        end
                        mprq_pkg::ACT_POP:
                        begin
                            state_next = nonempty ? mprq_pkg::ST_POP : mprq_pkg::ST_FIRST;
                        end
                        mprq_pkg::ACT_CLEAR:
                        begin
                            rd_idx_next = '0;
                            wr_idx_next = '0;
                            state_next  = mprq_pkg::ST_FIRST;
                        end
                        mprq_pkg::ACT_REBASE:
                        begin
                            state_next = nonempty ? mprq_pkg::ST_RB : mprq_pkg::ST_FIRST;
                        end
                        default:
                        begin
                            state_next = mprq_pkg::ST_FIRST;
                        end
                    endcase
                end
            end
            mprq_pkg::ST_PUT:
            begin
                // A put equal to the newest entry is skipped; a put into a full ring is dropped.
                if (!(nonempty && alu.eq))
                begin
                    if (mprq_pkg::next_slot(wr_idx_reg) == rd_idx_reg)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        we          = 1'b1;
                        waddr       = wr_idx_reg;
                        wdata       = pos_reg;
                        wr_idx_next = mprq_pkg::next_slot(wr_idx_reg);
                    end
                end
                state_next = mprq_pkg::ST_FIRST;
            end
            mprq_pkg::ST_POP:
            begin
                pv_next     = 1'b1;
                popped_next = rdata;
                rd_idx_next = mprq_pkg::next_slot(rd_idx_reg);
                state_next  = mprq_pkg::ST_FIRST;
            end
            mprq_pkg::ST_RB:
            begin
                // Rewrite the current entry and fetch the next one in the same cycle.
                if (alu.ge)
                begin
                    we    = 1'b1;
                    waddr = walk_reg;
                    wdata = alu.rebased;
                end
                walk_next = mprq_pkg::next_slot(walk_reg);
                raddr     = mprq_pkg::next_slot(walk_reg);
                if (mprq_pkg::next_slot(walk_reg) == wr_idx_reg)
                begin
                    state_next = mprq_pkg::ST_FIRST;
                end
            end
            mprq_pkg::ST_FIRST:
            begin
                raddr      = rd_idx_reg;
                state_next = mprq_pkg::ST_LAST;
            end
            mprq_pkg::ST_LAST:
            begin
                first_next = rdata;
                raddr      = mprq_pkg::prev_slot(wr_idx_reg);
                state_next = mprq_pkg::ST_DONE;
            end
            mprq_pkg::ST_DONE:
            begin
                raddr = mprq_pkg::prev_slot(wr_idx_reg);
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     mprq_pkg::CNT_W'(count),
                                     ovf_reg,
                                     popped_reg,
                                     pv_reg,
                                     (nonempty ? rdata : mprq_pkg::pos_t'(0)),
                                     (nonempty ? first_reg : mprq_pkg::pos_t'(0)),
                                     nonempty};
                    state_next    = mprq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mprq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mprq_pkg::ST_IDLE;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        walk_reg    <= walk_next;
        act_reg     <= act_next;
        pos_reg     <= pos_next;
        bstart_reg  <= bstart_next;
        bend_reg    <= bend_next;
        first_reg   <= first_next;
        popped_reg  <= popped_next;
        pv_reg      <= pv_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer.
    `MPRQ_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> !s_tready,
        "block still ready right after accepting an item")
    `MPRQ_ASSERT(a_ovf_only_put, clk, rst_n,
        (out_load && ovf_reg) |-> (act_reg == mprq_pkg::ACT_PUT),
        "overflow reported for an action other than put")
    `MPRQ_ASSERT(a_pop_only_pop, clk, rst_n,
        (out_load && pv_reg) |-> (act_reg == mprq_pkg::ACT_POP),
        "popped entry reported for an action other than pop")
    `MPRQ_NEVER(a_walk_in_range, clk, rst_n,
        (state_reg == mprq_pkg::ST_RB) && (walk_reg == wr_idx_reg),
        "rebase walk reached the write slot")
    `MPRQ_ASSERT(a_load_sets_valid, clk, rst_n, out_load |=> m_tvalid,
        "result loaded but output not valid")

endmodule

### hdl/mprq_store.sv
// Marker store: one write port and one registered read port.
module mprq_store (
    input  logic           clk,
    input  logic           we,
    input  mprq_pkg::idx_t waddr,
    input  mprq_pkg::pos_t wdata,
    input  mprq_pkg::idx_t raddr,
    output mprq_pkg::pos_t rdata
);

    mprq_pkg::pos_t mem [mprq_pkg::DEPTH];
    mprq_pkg::pos_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mprq_alu.sv
// Shared compare and rebase unit applied to one stored position at a time.
module mprq_alu (
    input  mprq_pkg::pos_t     value,
    input  mprq_pkg::pos_t     position,
    input  mprq_pkg::pos_t     buffer_start,
    input  mprq_pkg::pos_t     buffer_end,
    output mprq_pkg::alu_res_t res
);

    // Compares against the buffer end and the position; folds overshoot past the buffer end onto the buffer start.
    always_comb
    begin
        res.ge      = (value >= buffer_end);
        res.eq      = (value == position);
        res.rebased = mprq_pkg::pos_t'(buffer_start + mprq_pkg::pos_t'(value - buffer_end));
    end

endmodule

### dv/tb.sv
// Self-checking testbench for the marker position ring queue with a queue-state predictor.
`timescale 1ns / 100ps

module tb;

    // One action as it travels on the input channel.
    typedef struct {
        mprq_pkg::action_t act;
        mprq_pkg::pos_t    pos;
        mprq_pkg::pos_t    bstart;
        mprq_pkg::pos_t    bend;
    } marker_cmd_t;

    // Queue status reported after each action.
    typedef struct packed {
        logic           not_empty;
        mprq_pkg::pos_t first_pos;
        mprq_pkg::pos_t last_pos;
        logic           popped_valid;
        mprq_pkg::pos_t popped_pos;
        logic           overflow;
        logic [3:0]     entry_count;
    } ring_status_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [15:0] position, [31:16] buffer_start, [47:32] buffer_end
    logic [mprq_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // [1:0] action
    logic [1:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [0] not_empty, [16:1] first_position, [32:17] last_position,
    // [33] popped_valid, [49:34] popped_position, [50] overflow,
    // [54:51] entry_count, [55] zero
    logic [mprq_pkg::OUT_DATA_W-1:0] m_tdata;

    marker_cmd_t  pending_cmds[$];
    ring_status_t expected_status[$];
    marker_cmd_t  active_cmd;

    // Predicted queue contents.
    mprq_pkg::idx_t ring_rd = '0;
    mprq_pkg::idx_t ring_wr = '0;
    mprq_pkg::pos_t ring_mem[mprq_pkg::DEPTH];

    int error_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    marker_position_ring_queue_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic mprq_pkg::idx_t slot_after(input mprq_pkg::idx_t i);
        return mprq_pkg::idx_t'((int'(i) + 1) % mprq_pkg::DEPTH);
    endfunction

    function automatic mprq_pkg::idx_t slot_before(input mprq_pkg::idx_t i);
        return mprq_pkg::idx_t'((int'(i) + mprq_pkg::DEPTH - 1) % mprq_pkg::DEPTH);
    endfunction

    // Applies one action to the predicted queue and returns the status it reports.
    function automatic ring_status_t apply_marker_action(input marker_cmd_t c);
        ring_status_t   r;
        logic           occupied;
        mprq_pkg::idx_t i;
        r = '0;
        occupied = (ring_rd != ring_wr);
        case (c.act)
            mprq_pkg::ACT_PUT:
            begin
                // A repeat of the newest position is skipped; a full queue drops the put.
                if (!(occupied && ring_mem[slot_before(ring_wr)] == c.pos))
                begin
                    if (slot_after(ring_wr) == ring_rd)
                        r.overflow = 1'b1;
                    else
                    begin
                        ring_mem[ring_wr] = c.pos;
                        ring_wr = slot_after(ring_wr);
                    end
                end
            end
            mprq_pkg::ACT_POP:
            begin
                if (occupied)
                begin
                    r.popped_valid = 1'b1;
                    r.popped_pos = ring_mem[ring_rd];
                    ring_rd = slot_after(ring_rd);
                end
            end
            mprq_pkg::ACT_CLEAR:
            begin
                ring_rd = '0;
                ring_wr = '0;
            end
            default:
            begin
                // Positions at or past the buffer end wrap to the start plus overshoot.
                for (i = ring_rd; i != ring_wr; i = slot_after(i))
                    if (ring_mem[i] >= c.bend)
                        ring_mem[i] = mprq_pkg::pos_t'(c.bstart
                                      + mprq_pkg::pos_t'(ring_mem[i] - c.bend));
            end
        endcase
        r.not_empty = (ring_rd != ring_wr);
        if (r.not_empty)
        begin
            r.first_pos = ring_mem[ring_rd];
            r.last_pos = ring_mem[slot_before(ring_wr)];
        end
        r.entry_count = 4'((int'(ring_wr) + mprq_pkg::DEPTH - int'(ring_rd)) % mprq_pkg::DEPTH);
        return r;
    endfunction

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void queue_cmd(input mprq_pkg::action_t a, input mprq_pkg::pos_t p,
                                      input mprq_pkg::pos_t s, input mprq_pkg::pos_t e);
        marker_cmd_t c;
        c.act = a;
        c.pos = p;
        c.bstart = s;
        c.bend = e;
        pending_cmds.push_back(c);
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            error_count++;
        end
    endtask

    // Sender: predicts each accepted item, then waits a drawn gap before the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_status.push_back(apply_marker_action(active_cmd));
                if ($urandom_range(0, 31) == 0)
                    send_quiet = !send_quiet;
                send_wait = draw_wait(send_quiet);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    active_cmd = pending_cmds.pop_front();
                    s_tdata <= {active_cmd.bend, active_cmd.bstart, active_cmd.pos};
                    s_tuser <= active_cmd.act;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted item, then stalls for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        ring_status_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result item arrived with no expectation: 0x%0h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("not_empty", 32'(want.not_empty), 32'(m_tdata[0]));
                    check_field("first_position", 32'(want.first_pos), 32'(m_tdata[16:1]));
                    check_field("last_position", 32'(want.last_pos), 32'(m_tdata[32:17]));
                    check_field("popped_valid", 32'(want.popped_valid), 32'(m_tdata[33]));
                    check_field("popped_position", 32'(want.popped_pos),
                                32'(m_tdata[49:34]));
                    check_field("overflow", 32'(want.overflow), 32'(m_tdata[50]));
                    check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[54:51]));
                end
                if ($urandom_range(0, 31) == 0)
                    recv_quiet = !recv_quiet;
                recv_wait = draw_wait(recv_quiet);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int             phase_kind;
        int             roll;
        mprq_pkg::pos_t last_put;
        mprq_pkg::pos_t p;
        mprq_pkg::pos_t s;
        mprq_pkg::pos_t e;

        foreach (ring_mem[k])
            ring_mem[k] = '0;
        last_put = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty cases, duplicate put, filling to overflow, rebase wrap.
        queue_cmd(mprq_pkg::ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_cmd(mprq_pkg::ACT_REBASE, 16'h1234, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'hFFFF, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'h8000, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'h7FFF, 16'h0000, 16'h0000);
        for (int k = 0; k < 11; k++)
            queue_cmd(mprq_pkg::ACT_PUT, mprq_pkg::pos_t'(16'h5555 + k * 16'h1111),
                      16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_PUT, 16'hAAAA, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_REBASE, 16'h0000, 16'hFFFF, 16'h0000);
        queue_cmd(mprq_pkg::ACT_REBASE, 16'h0000, 16'h0000, 16'hFFFF);
        queue_cmd(mprq_pkg::ACT_REBASE, 16'h0000, 16'h0100, 16'h7FFF);
        queue_cmd(mprq_pkg::ACT_POP, 16'h0000, 16'h0000, 16'h0000);
        queue_cmd(mprq_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Hold the sender until every result of the directed part has come back.
        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge clk);

        // Random part in phases that lean toward filling, draining or a mix.
        phase_kind = 0;
        for (int n = 0; n < 1000; n++)
        begin
            if (n % 40 == 0)
                phase_kind = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            s = mprq_pkg::pos_t'($urandom);
            e = mprq_pkg::pos_t'($urandom);
            case ($urandom_range(0, 3))
                0: p = last_put;
                1: p = mprq_pkg::pos_t'(last_put + $urandom_range(0, 64));
                default: p = mprq_pkg::pos_t'($urandom);
            endcase
            if (roll < 3)
                queue_cmd(mprq_pkg::ACT_CLEAR, p, s, e);
            else if (roll < 15)
            begin
                // Put the buffer end near recent positions so both sides of it occur.
                if ($urandom_range(0, 1) == 1)
                    e = mprq_pkg::pos_t'(last_put + $urandom_range(0, 64) - 32);
                queue_cmd(mprq_pkg::ACT_REBASE, p, s, e);
            end
            else if ((phase_kind == 0 && roll < 75) || (phase_kind == 1 && roll < 35) ||
                     (phase_kind == 2 && roll < 58))
            begin
                queue_cmd(mprq_pkg::ACT_PUT, p, s, e);
                last_put = p;
            end
            else
                queue_cmd(mprq_pkg::ACT_POP, p, s, e);
        end

        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4 * mprq_pkg::DEPTH) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
